[design/mrt_pkg.sv]
// shared types, constants and helpers of the primality test unit
package mrt_pkg;

    localparam int TRIAL_PRIMES   = 100;
    localparam int WITNESS_ROUNDS = 10;
    localparam int TABLE_DEPTH    = 100;
    localparam int WORD_W         = 64;
    localparam int PRIME_W        = 10;
    localparam int IDX_W          = 7;
    localparam int SCNT_W         = 6;
    localparam int CNT_W          = 6;

    localparam logic [PRIME_W-1:0] PRIME_TABLE [TABLE_DEPTH] = '{
        10'd2,   10'd3,   10'd5,   10'd7,   10'd11,  10'd13,  10'd17,  10'd19,  10'd23,  10'd29,
        10'd31,  10'd37,  10'd41,  10'd43,  10'd47,  10'd53,  10'd59,  10'd61,  10'd67,  10'd71,
        10'd73,  10'd79,  10'd83,  10'd89,  10'd97,  10'd101, 10'd103, 10'd107, 10'd109, 10'd113,
        10'd127, 10'd131, 10'd137, 10'd139, 10'd149, 10'd151, 10'd157, 10'd163, 10'd167, 10'd173,
        10'd179, 10'd181, 10'd191, 10'd193, 10'd197, 10'd199, 10'd211, 10'd223, 10'd227, 10'd229,
        10'd233, 10'd239, 10'd241, 10'd251, 10'd257, 10'd263, 10'd269, 10'd271, 10'd277, 10'd281,
        10'd283, 10'd293, 10'd307, 10'd311, 10'd313, 10'd317, 10'd331, 10'd337, 10'd347, 10'd349,
        10'd353, 10'd359, 10'd367, 10'd373, 10'd379, 10'd383, 10'd389, 10'd397, 10'd401, 10'd409,
        10'd419, 10'd421, 10'd431, 10'd433, 10'd439, 10'd443, 10'd449, 10'd457, 10'd461, 10'd463,
        10'd467, 10'd479, 10'd487, 10'd491, 10'd499, 10'd503, 10'd509, 10'd521, 10'd523, 10'd541
    };

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_TRIAL,
        OP_SPLIT_INIT,
        OP_SPLIT_STEP,
        OP_ROUND_INIT,
        OP_MUL_ACC,
        OP_MUL_BASE,
        OP_SQ_INIT,
        OP_MUL_SQ
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic [IDX_W-1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic n_lt2;
        logic n_eq_p;
        logic rem_zero;
        logic split_more;
        logic e_zero;
        logic e_lsb;
        logic acc_one;
        logic acc_nm1;
        logic scnt_gt1;
    } dp_status_t;

    function automatic logic [WORD_W-1:0] add_mod(input logic [WORD_W-1:0] x,
                                                  input logic [WORD_W-1:0] y,
                                                  input logic [WORD_W-1:0] m);
        logic [WORD_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[WORD_W-1:0];
    endfunction

endpackage

[design/mrt_ifs.sv]
// valid/ready channel interfaces for candidates and verdicts
interface mrt_cand_if;
    logic        valid;
    logic        ready;
    logic [63:0] candidate;
    modport source (output valid, output candidate, input ready);
    modport sink (input valid, input candidate, output ready);
endinterface

interface mrt_res_if;
    logic valid;
    logic ready;
    logic probably_prime;
    modport source (output valid, output probably_prime, input ready);
    modport sink (input valid, input probably_prime, output ready);
endinterface

[design/primality_test_64bit_unit.sv]
// top level of the 64-bit miller-rabin primality test unit
//
//  channel  | dir | payload
//  ---------+-----+-------------------------------
//  cand     | in  | candidate      [63:0] unsigned
//  res      | out | probably_prime [0]
//
// one item at a time; trial division tests one table prime after another,
// and each modular product runs in the bit-serial double-and-add multiplier
// typical large prime: run time is dominated by the shared multiplier
// small factors end early: the test stops at the first table prime that divides the candidate
// a new item is taken while the previous verdict waits in the output register
// asynchronous active-low reset returns the sequencer to idle
module primality_test_64bit_unit (
    input  logic      clk,
    input  logic      rst_n,
    mrt_cand_if.sink  cand,
    mrt_res_if.source res
);
    import mrt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    mrt_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cand.valid),
        .in_ready  (cand.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_prime (res.probably_prime),
        .cmd       (cmd),
        .status    (status)
    );

    mrt_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .candidate (cand.candidate),
        .status    (status)
    );
endmodule

[design/mrt_datapath.sv]
// datapath: operand registers, bit-serial modular multiplier and trial remainder
module mrt_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mrt_pkg::dp_cmd_t              cmd,
    input  logic [mrt_pkg::WORD_W-1:0]    candidate,
    output mrt_pkg::dp_status_t           status
);
    import mrt_pkg::*;

    typedef enum logic {UNIT_TRIAL, UNIT_MUL} unit_mode_t;
    typedef enum logic {DEST_ACC, DEST_BASE} mul_dest_t;

    logic [WORD_W-1:0]  n_reg, n_next;
    logic [WORD_W-1:0]  dodd_reg, dodd_next;
    logic [SCNT_W-1:0]  s_reg, s_next;
    logic [SCNT_W-1:0]  scnt_reg, scnt_next;
    logic [WORD_W-1:0]  e_reg, e_next;
    logic [WORD_W-1:0]  acc_reg, acc_next;
    logic [WORD_W-1:0]  base_reg, base_next;
    logic [WORD_W-1:0]  ma_reg, ma_next;
    logic [WORD_W-1:0]  mb_reg, mb_next;
    logic [WORD_W-1:0]  macc_reg, macc_next;
    logic [PRIME_W-1:0] p_reg, p_next;
    logic [PRIME_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    unit_mode_t         mode_reg, mode_next;
    mul_dest_t          dest_reg, dest_next;

    logic [WORD_W-1:0]  dbl;
    logic [WORD_W-1:0]  step_val;
    logic [PRIME_W:0]   tr;

    always_comb
    begin
        dbl      = add_mod(macc_reg, macc_reg, n_reg);
        step_val = mb_reg[WORD_W-1] ? add_mod(dbl, ma_reg, n_reg) : dbl;
        tr       = {rem_reg, mb_reg[WORD_W-1]};
        if (tr >= {1'b0, p_reg})
        begin
            tr = tr - {1'b0, p_reg};
        end
    end

    always_comb
    begin
        n_next    = n_reg;
        dodd_next = dodd_reg;
        s_next    = s_reg;
        scnt_next = scnt_reg;
        e_next    = e_reg;
        acc_next  = acc_reg;
        base_next = base_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        macc_next = macc_reg;
        p_next    = p_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        mode_next = mode_reg;
        dest_next = dest_reg;
        if (busy_reg)
        begin
            mb_next  = mb_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (mode_reg == UNIT_MUL)
            begin
                macc_next = step_val;
            end
            else
            begin
                rem_next = tr[PRIME_W-1:0];
            end
            if (cnt_reg == CNT_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                if (mode_reg == UNIT_MUL)
                begin
                    if (dest_reg == DEST_ACC)
                    begin
                        acc_next = step_val;
                    end
                    else
                    begin
                        base_next = step_val;
                    end
                end
            end
        end
        else
        begin
            case (cmd.op)
                OP_LOAD:
                begin
                    n_next = candidate;
                end
                OP_TRIAL:
                begin
                    p_next    = PRIME_TABLE[cmd.idx];
                    rem_next  = '0;
                    mb_next   = n_reg;
                    cnt_next  = '0;
                    mode_next = UNIT_TRIAL;
                    busy_next = 1'b1;
                end
                OP_SPLIT_INIT:
                begin
                    dodd_next = n_reg - 1'b1;
                    s_next    = '0;
                end
                OP_SPLIT_STEP:
                begin
                    dodd_next = dodd_reg >> 1;
                    s_next    = s_reg + 1'b1;
                end
                OP_ROUND_INIT:
                begin
                    acc_next  = WORD_W'(1);
                    base_next = WORD_W'(PRIME_TABLE[cmd.idx]);
                    e_next    = dodd_reg;
                end
                OP_MUL_ACC:
                begin
                    ma_next   = acc_reg;
                    mb_next   = base_reg;
                    macc_next = '0;
                    cnt_next  = '0;
                    mode_next = UNIT_MUL;
                    dest_next = DEST_ACC;
                    busy_next = 1'b1;
                end
                OP_MUL_BASE:
                begin
                    ma_next   = base_reg;
                    mb_next   = base_reg;
                    macc_next = '0;
                    cnt_next  = '0;
                    e_next    = e_reg >> 1;
                    mode_next = UNIT_MUL;
                    dest_next = DEST_BASE;
                    busy_next = 1'b1;
                end
                OP_SQ_INIT:
                begin
                    scnt_next = s_reg;
                end
                OP_MUL_SQ:
                begin
                    ma_next   = acc_reg;
                    mb_next   = acc_reg;
                    macc_next = '0;
                    cnt_next  = '0;
                    scnt_next = scnt_reg - 1'b1;
                    mode_next = UNIT_MUL;
                    dest_next = DEST_ACC;
                    busy_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        dodd_reg <= dodd_next;
        s_reg    <= s_next;
        scnt_reg <= scnt_next;
        e_reg    <= e_next;
        acc_reg  <= acc_next;
        base_reg <= base_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        macc_reg <= macc_next;
        p_reg    <= p_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        mode_reg <= mode_next;
        dest_reg <= dest_next;
    end

    always_comb
    begin
        status.busy       = busy_reg;
        status.n_lt2      = (n_reg < WORD_W'(2));
        status.n_eq_p     = (n_reg == WORD_W'(p_reg));
        status.rem_zero   = (rem_reg == '0);
        status.split_more = !dodd_reg[0] && (dodd_reg != '0);
        status.e_zero     = (e_reg == '0);
        status.e_lsb      = e_reg[0];
        status.acc_one    = (acc_reg == WORD_W'(1));
        status.acc_nm1    = (acc_reg == n_reg - 1'b1);
        status.scnt_gt1   = (scnt_reg > SCNT_W'(1));
    end
endmodule

[design/mrt_controller.sv]
// controller: sequences trial division and witness rounds, holds the verdict
module mrt_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_prime,
    output mrt_pkg::dp_cmd_t    cmd,
    input  mrt_pkg::dp_status_t status
);
    import mrt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK_SMALL,
        ST_TRIAL_ISSUE,
        ST_TRIAL_WAIT,
        ST_SPLIT,
        ST_ROUND_INIT,
        ST_POW_CHECK,
        ST_MUL_ACC_WAIT,
        ST_MUL_BASE_WAIT,
        ST_POST_CHECK,
        ST_SQ_CHECK,
        ST_SQ_WAIT,
        ST_ROUND_PASS,
        ST_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             verdict_reg, verdict_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_prime_reg, out_prime_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_prime = out_prime_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        verdict_next   = verdict_reg;
        out_valid_next = out_valid_reg;
        out_prime_next = out_prime_reg;
        cmd.op         = OP_NONE;
        cmd.idx        = idx_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_CHECK_SMALL;
                end
            end
            ST_CHECK_SMALL:
            begin
                idx_next = '0;
                if (status.n_lt2)
                begin
                    verdict_next = 1'b0;
                    state_next   = ST_DONE;
                end
                else
                begin
                    state_next = ST_TRIAL_ISSUE;
                end
            end
            ST_TRIAL_ISSUE:
            begin
                cmd.op     = OP_TRIAL;
                state_next = ST_TRIAL_WAIT;
            end
            ST_TRIAL_WAIT:
            begin
                if (!status.busy)
                begin
                    if (status.n_eq_p)
                    begin
                        verdict_next = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else if (status.rem_zero)
                    begin
                        verdict_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                    else if (idx_reg == IDX_W'(TRIAL_PRIMES - 1))
                    begin
                        cmd.op     = OP_SPLIT_INIT;
                        state_next = ST_SPLIT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_TRIAL_ISSUE;
                    end
                end
            end
            ST_SPLIT:
            begin
                if (status.split_more)
                begin
                    cmd.op = OP_SPLIT_STEP;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_ROUND_INIT;
                end
            end
            ST_ROUND_INIT:
            begin
                cmd.op     = OP_ROUND_INIT;
                state_next = ST_POW_CHECK;
            end
            ST_POW_CHECK:
            begin
                if (status.e_zero)
                begin
                    state_next = ST_POST_CHECK;
                end
                else if (status.e_lsb)
                begin
                    cmd.op     = OP_MUL_ACC;
                    state_next = ST_MUL_ACC_WAIT;
                end
                else
                begin
                    cmd.op     = OP_MUL_BASE;
                    state_next = ST_MUL_BASE_WAIT;
                end
            end
            ST_MUL_ACC_WAIT:
            begin
                if (!status.busy)
                begin
                    cmd.op     = OP_MUL_BASE;
                    state_next = ST_MUL_BASE_WAIT;
                end
            end
            ST_MUL_BASE_WAIT:
            begin
                if (!status.busy)
                begin
                    state_next = ST_POW_CHECK;
                end
            end
            ST_POST_CHECK:
            begin
                if (status.acc_one || status.acc_nm1)
                begin
                    state_next = ST_ROUND_PASS;
                end
                else
                begin
                    cmd.op     = OP_SQ_INIT;
                    state_next = ST_SQ_CHECK;
                end
            end
            ST_SQ_CHECK:
            begin
                if (status.scnt_gt1)
                begin
                    cmd.op     = OP_MUL_SQ;
                    state_next = ST_SQ_WAIT;
                end
                else
                begin
                    verdict_next = 1'b0;
                    state_next   = ST_DONE;
                end
            end
            ST_SQ_WAIT:
            begin
                if (!status.busy)
                begin
                    if (status.acc_one)
                    begin
                        verdict_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                    else if (status.acc_nm1)
                    begin
                        state_next = ST_ROUND_PASS;
                    end
                    else
                    begin
                        state_next = ST_SQ_CHECK;
                    end
                end
            end
            ST_ROUND_PASS:
            begin
                if (idx_reg == IDX_W'(WITNESS_ROUNDS - 1))
                begin
                    verdict_next = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_ROUND_INIT;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_prime_next = verdict_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            verdict_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_prime_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            verdict_reg   <= verdict_next;
            out_valid_reg <= out_valid_next;
            out_prime_reg <= out_prime_next;
        end
    end
endmodule

[test/tb_primality_test_64bit_unit.sv]
// testbench for the 64-bit primality test unit: directed and random candidates, checked on the fly
module tb_primality_test_64bit_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mrt_pkg::*;

    localparam int WATCHDOG_LIMIT = 400000;
    localparam int HOLD_CYCLES    = 3000;
    localparam int DRAIN_CYCLES   = 300;

    typedef enum logic [2:0] {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH,
        PH_PRESSURE
    } phase_t;

    typedef struct {
        logic [63:0] value;
        phase_t      phase;
    } cand_item_t;

    logic clk;
    logic rst_n;

    mrt_cand_if cand ();
    mrt_res_if  res ();

    primality_test_64bit_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cand  (cand.sink),
        .res   (res.source)
    );

    cand_item_t pending_q[$];
    logic       verdict_q[$];
    int         errors         = 0;
    int         verdicts_seen  = 0;
    int         primes_seen    = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         hold_left;
    logic       hold_req;
    logic       hold_done      = 1'b0;
    logic       cand_took      = 1'b0;
    int         quiet_cycles   = 0;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic [63:0] mulmod_exact(input logic [63:0] a, input logic [63:0] b,
                                                 input logic [63:0] m);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return 64'(prod % {64'd0, m});
    endfunction

    function automatic logic [63:0] powmod(input logic [63:0] b, input logic [63:0] e,
                                           input logic [63:0] m);
        logic [63:0] acc;
        acc = 64'd1;
        while (e != 64'd0)
        begin
            if (e[0])
            begin
                acc = mulmod_exact(acc, b, m);
            end
            b = mulmod_exact(b, b, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic logic strong_round(input logic [63:0] n, input logic [63:0] base);
        logic [63:0] d;
        logic [63:0] x;
        int          s;
        d = n - 64'd1;
        s = 0;
        while (d[0] == 1'b0 && d != 64'd0)
        begin
            d = d >> 1;
            s++;
        end
        x = powmod(base % n, d, n);
        if (x == 64'd1 || x == n - 64'd1)
        begin
            return 1'b1;
        end
        while (s > 1)
        begin
            s--;
            x = mulmod_exact(x, x, n);
            if (x == 64'd1)
            begin
                return 1'b0;
            end
            if (x == n - 64'd1)
            begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic predict_prime(input logic [63:0] n);
        logic [63:0] p;
        if (n < 64'd2)
        begin
            return 1'b0;
        end
        for (int i = 0; i < TRIAL_PRIMES && i < TABLE_DEPTH; i++)
        begin
            p = 64'(PRIME_TABLE[i]);
            if (n == p)
            begin
                return 1'b1;
            end
            if (n % p == 64'd0)
            begin
                return 1'b0;
            end
        end
        for (int i = 0; i < WITNESS_ROUNDS && i < TABLE_DEPTH; i++)
        begin
            if (!strong_round(n, 64'(PRIME_TABLE[i])))
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        cand_item_t it;
        logic       hold_now;
        if (!rst_n)
        begin
            cand.valid     <= 1'b0;
            cand.candidate <= 64'd0;
            hold_req       <= 1'b0;
        end
        else
        begin
            hold_now = 1'b0;
            if (!cand.valid || cand_took)
            begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    it = pending_q.pop_front();
                    cand.valid     <= 1'b1;
                    cand.candidate <= it.value;
                    case (it.phase)
                        PH_FREE:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                        PH_SEND_IDLE:  begin send_idle_pct = 74; recv_stall_pct = 0;  end
                        PH_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                        PH_BOTH:       begin send_idle_pct = 33; recv_stall_pct = 33; end
                        default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    endcase
                    if (it.phase == PH_PRESSURE && !hold_done)
                    begin
                        hold_now  = 1'b1;
                        hold_done = 1'b1;
                    end
                end
                else
                begin
                    cand.valid <= 1'b0;
                end
            end
            hold_req <= hold_now;
        end
    end

    // long receiver hold-off
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_req)
        begin
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
        end
        else
        begin
            res.ready <= (hold_left == 0 && !hold_req) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        logic want;
        cand_took = 1'b0;
        if (rst_n)
        begin
            if (cand.valid && cand.ready)
            begin
                cand_took = 1'b1;
                verdict_q = {verdict_q, predict_prime(cand.candidate)};
            end
            if (res.valid && res.ready)
            begin
                verdicts_seen++;
                if (res.probably_prime)
                begin
                    primes_seen++;
                end
                if (verdict_q.size() == 0)
                begin
                    $error("probably_prime: unexpected item, actual %0b", res.probably_prime);
                    errors++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (res.probably_prime !== want)
                    begin
                        $error("probably_prime: expected %0b actual %0b", want,
                               res.probably_prime);
                        errors++;
                    end
                end
            end
            if ((cand.valid && cand.ready) || (res.valid && res.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand_candidate();
        logic [63:0] big_primes[4];
        int          kind;
        big_primes = '{64'd18446744073709551557, 64'd2305843009213693951,
                       64'd4294967291, 64'd1000000007};
        kind = $urandom_range(9);
        if ($urandom_range(49) == 0)
        begin
            return big_primes[$urandom_range(3)];
        end
        if (kind <= 3)
        begin
            return {$urandom, $urandom};
        end
        if (kind <= 6)
        begin
            return {$urandom, $urandom} * 64'(PRIME_TABLE[$urandom_range(TABLE_DEPTH - 1)]);
        end
        return 64'($urandom_range(100000));
    endfunction

    task automatic queue_item(input logic [63:0] v, input phase_t ph);
        cand_item_t it;
        it.value = v;
        it.phase = ph;
        pending_q = {pending_q, it};
    endtask

    initial
    begin
        logic [63:0] directed[$];
        phase_t      phases[5];
        rst_n = 1'b0;

        directed = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd541, 64'd542, 64'd543, 64'd547,
                     64'd561, 64'd85849, 64'd299209, 64'd25326001, 64'd1000000007,
                     64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
                     64'h8000_0000_0000_0000, 64'd18446744073709551557,
                     64'd2305843009213693951, 64'd3825123056546413051,
                     64'd18446743979220271189};
        foreach (directed[i])
        begin
            queue_item(directed[i], PH_FREE);
        end
        phases = '{PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_PRESSURE};
        foreach (phases[p])
        begin
            for (int i = 0; i < 20; i++)
            begin
                // pressure phase uses cheap items so the unit fills quickly
                if (phases[p] == PH_PRESSURE && i < 6)
                begin
                    queue_item(64'($urandom_range(1000)) * 64'd2, phases[p]);
                end
                else
                begin
                    queue_item(rand_candidate(), phases[p]);
                end
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_q.size() > 0 || cand.valid || verdict_q.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d candidates over free, sender-idle, receiver-stall, mixed",
                 verdicts_seen);
        $display("and back-pressure phases; %0d reported probably prime", primes_seen);
        if (errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[primality_test_64bit_unit.f]
design/mrt_pkg.sv
design/mrt_ifs.sv
design/mrt_datapath.sv
design/mrt_controller.sv
design/primality_test_64bit_unit.sv
test/tb_primality_test_64bit_unit.sv
